// ===== rtl/rhd_pkg.sv =====
// Shared constants and types for the register hazard detector.
`timescale 1ns / 1ps
`default_nettype none
package rhd_pkg;

  localparam int NUM_REGS   = 32;
  localparam int INDEX_BITS = 16;
  localparam int REG_BITS   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int ENTRY_BITS = 2 + INDEX_BITS;

  localparam logic [1:0] FMT_R = 2'd0;
  localparam logic [1:0] FMT_I = 2'd1;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } access_kind_t;

  typedef enum logic [1:0] {
    HZ_RAW = 2'd0,
    HZ_WAR = 2'd1,
    HZ_WAW = 2'd2
  } hazard_t;

  typedef struct packed {
    access_kind_t            kind;
    logic [INDEX_BITS-1:0]   idx;
  } entry_t;

  typedef struct packed {
    logic                    we;
    logic [REG_BITS-1:0]     addr;
    entry_t                  data;
  } ram_wr_t;

  typedef struct packed {
    hazard_t                 kind;
    logic [4:0]              reg_num;
    logic [15:0]             earlier;
    logic [15:0]             later;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/rhd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]               wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/rhd_core.sv =====
// Access sequencer: read-modify-write of the register table and result output.
`timescale 1ns / 1ps
`default_nettype none
module rhd_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        inst_format,
  input  wire logic [4:0]                        src_a,
  input  wire logic [4:0]                        src_b,
  input  wire logic [4:0]                        dest,
  input  wire logic                              src_a_used,
  input  wire logic                              src_b_used,
  input  wire logic                              dest_used,
  output rhd_pkg::ram_wr_t                       ram_wr,
  output logic [rhd_pkg::REG_BITS-1:0]           ram_raddr,
  input  wire logic [rhd_pkg::ENTRY_BITS-1:0]    ram_rdata,
  output logic                                   result_valid,
  output logic [1:0]                             hazard_kind,
  output logic [4:0]                             reg_number,
  output logic [15:0]                            earlier_index,
  output logic [15:0]                            later_index,
  output logic                                   last_of_item
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A,
    ST_B,
    ST_C,
    ST_D,
    ST_FLUSH
  } state_t;

  state_t                           state;
  logic [2:0]                       slot_en;
  logic [2:0]                       slot_wr;
  logic [rhd_pkg::REG_BITS-1:0]     slot_reg [3];
  logic [4:0]                       slot_num [3];
  logic [rhd_pkg::NUM_REGS-1:0]     valid;
  logic                             vld_q;
  logic                             fwd_valid;
  logic [rhd_pkg::REG_BITS-1:0]     fwd_addr;
  rhd_pkg::entry_t                  fwd_entry;
  logic                             pend_valid;
  rhd_pkg::result_t                 pend;
  logic [rhd_pkg::INDEX_BITS-1:0]   instr_counter;

  logic                             accept;
  logic [1:0]                       rd_sel;
  logic [1:0]                       ev_sel;
  logic                             ev_active;
  rhd_pkg::entry_t                  prev;
  logic                             hz_found;
  rhd_pkg::hazard_t                 hz_kind;
  rhd_pkg::result_t                 hz_res;
  logic [2:0]                       en_next;
  logic [2:0]                       wr_next;
  logic [4:0]                       num_next [3];
  logic                             ok_a;
  logic                             ok_b;
  logic                             ok_d;

  assign busy   = state inside {ST_A, ST_B, ST_C, ST_D};
  assign accept = start && !busy;

  assign ok_a = int'(src_a) < rhd_pkg::NUM_REGS;
  assign ok_b = int'(src_b) < rhd_pkg::NUM_REGS;
  assign ok_d = int'(dest) < rhd_pkg::NUM_REGS;

  always_comb begin
    en_next     = 3'b000;
    wr_next     = 3'b000;
    num_next[0] = src_a;
    num_next[1] = src_b;
    num_next[2] = dest;
    case (inst_format)
      rhd_pkg::FMT_R: begin
        en_next = {dest_used && ok_d, src_b_used && ok_b, src_a_used && ok_a};
        wr_next = 3'b100;
      end
      rhd_pkg::FMT_I: begin
        en_next = {1'b0, src_b_used && ok_b, src_a_used && ok_a};
        wr_next = 3'b010;
      end
      default: begin
        en_next = 3'b000;
      end
    endcase
  end

  always_comb begin
    rd_sel    = 2'd0;
    ev_sel    = 2'd0;
    ev_active = 1'b0;
    case (state)
      ST_B: begin
        rd_sel    = 2'd1;
        ev_sel    = 2'd0;
        ev_active = 1'b1;
      end
      ST_C: begin
        rd_sel    = 2'd2;
        ev_sel    = 2'd1;
        ev_active = 1'b1;
      end
      ST_D: begin
        ev_sel    = 2'd2;
        ev_active = 1'b1;
      end
      default: begin
        rd_sel = 2'd0;
      end
    endcase
  end

  assign ram_raddr = slot_reg[rd_sel];

  always_comb begin
    prev = vld_q ? rhd_pkg::entry_t'(ram_rdata) : '0;
    if (fwd_valid && fwd_addr == slot_reg[ev_sel]) begin
      prev = fwd_entry;
    end
    ram_wr.we        = ev_active && slot_en[ev_sel];
    ram_wr.addr      = slot_reg[ev_sel];
    ram_wr.data.kind = slot_wr[ev_sel] ? rhd_pkg::KIND_WRITE : rhd_pkg::KIND_READ;
    ram_wr.data.idx  = instr_counter;
    hz_found = 1'b0;
    hz_kind  = rhd_pkg::HZ_RAW;
    if (prev.kind == rhd_pkg::KIND_WRITE) begin
      hz_found = 1'b1;
      hz_kind  = slot_wr[ev_sel] ? rhd_pkg::HZ_WAW : rhd_pkg::HZ_RAW;
    end else if (prev.kind == rhd_pkg::KIND_READ && slot_wr[ev_sel]) begin
      hz_found = 1'b1;
      hz_kind  = rhd_pkg::HZ_WAR;
    end
    hz_found       = hz_found && ram_wr.we;
    hz_res.kind    = hz_kind;
    hz_res.reg_num = slot_num[ev_sel];
    hz_res.earlier = 16'(prev.idx);
    hz_res.later   = 16'(instr_counter);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      valid         <= '0;
      fwd_valid     <= 1'b0;
      pend_valid    <= 1'b0;
      result_valid  <= 1'b0;
      instr_counter <= '0;
    end else begin
      result_valid <= pend_valid && (hz_found || state == ST_FLUSH);
      fwd_valid    <= ram_wr.we;
      fwd_addr     <= ram_wr.addr;
      fwd_entry    <= ram_wr.data;
      vld_q        <= valid[ram_raddr];
      if (ram_wr.we) begin
        valid[ram_wr.addr] <= 1'b1;
      end
      // hold one result back until it is known whether it is the last
      if (hz_found) begin
        pend       <= hz_res;
        pend_valid <= 1'b1;
        if (pend_valid) begin
          hazard_kind   <= pend.kind;
          reg_number    <= pend.reg_num;
          earlier_index <= pend.earlier;
          later_index   <= pend.later;
          last_of_item  <= 1'b0;
        end
      end
      case (state)
        ST_IDLE: state <= accept ? ST_A : ST_IDLE;
        ST_A: state <= ST_B;
        ST_B: state <= ST_C;
        ST_C: state <= ST_D;
        ST_D: state <= ST_FLUSH;
        ST_FLUSH: begin
          state <= accept ? ST_A : ST_IDLE;
          if (pend_valid) begin
            hazard_kind   <= pend.kind;
            reg_number    <= pend.reg_num;
            earlier_index <= pend.earlier;
            later_index   <= pend.later;
            last_of_item  <= 1'b1;
          end
          pend_valid <= 1'b0;
          if (instr_counter != {rhd_pkg::INDEX_BITS{1'b1}}) begin
            instr_counter <= instr_counter + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_en     <= en_next;
      slot_wr     <= wr_next;
      slot_reg[0] <= rhd_pkg::REG_BITS'(src_a);
      slot_reg[1] <= rhd_pkg::REG_BITS'(src_b);
      slot_reg[2] <= rhd_pkg::REG_BITS'(dest);
      slot_num[0] <= num_next[0];
      slot_num[1] <= num_next[1];
      slot_num[2] <= num_next[2];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/register_hazard_detector.sv =====
// Top level: register table RAM and access sequencer.
// An instruction passes through one table read, three read-modify-write
// steps (one per access slot, pipelined on the RAM port) and one flush step.
// A new instruction is accepted in the flush step or while idle.
// Results appear one per cycle, no stall.
// Synchronous reset clears the table valid bits, counter and control at once.
`timescale 1ns / 1ps
`default_nettype none
module register_hazard_detector (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  inst_format,
  input  wire logic [4:0]  src_a,
  input  wire logic [4:0]  src_b,
  input  wire logic [4:0]  dest,
  input  wire logic        src_a_used,
  input  wire logic        src_b_used,
  input  wire logic        dest_used,
  output logic             result_valid,
  output logic [1:0]       hazard_kind,
  output logic [4:0]       reg_number,
  output logic [15:0]      earlier_index,
  output logic [15:0]      later_index,
  output logic             last_of_item
);

  rhd_pkg::ram_wr_t                   ram_wr;
  logic [rhd_pkg::REG_BITS-1:0]       ram_raddr;
  logic [rhd_pkg::ENTRY_BITS-1:0]     ram_rdata;

  rhd_ram #(
    .WIDTH (rhd_pkg::ENTRY_BITS),
    .DEPTH (rhd_pkg::NUM_REGS)
  ) u_table (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rhd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .inst_format   (inst_format),
    .src_a         (src_a),
    .src_b         (src_b),
    .dest          (dest),
    .src_a_used    (src_a_used),
    .src_b_used    (src_b_used),
    .dest_used     (dest_used),
    .ram_wr        (ram_wr),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .result_valid  (result_valid),
    .hazard_kind   (hazard_kind),
    .reg_number    (reg_number),
    .earlier_index (earlier_index),
    .later_index   (later_index),
    .last_of_item  (last_of_item)
  );

endmodule
`default_nettype wire

// ===== rtl/rhd_checker.sv =====
// Port-level checker for the register hazard detector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rhd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        result_valid,
  input wire logic [15:0] earlier_index,
  input wire logic [15:0] later_index,
  input wire logic        last_of_item
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy ##2 busy)
    else $error("busy dropped during an instruction");

  a_free_after_item: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##5 !busy)
    else $error("busy held past the flush cycle");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_of_item |=> !result_valid)
    else $error("word right after the last word of an instruction");

  a_index_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> earlier_index <= later_index)
    else $error("earlier index above later index");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !busy && !result_valid)
    else $error("activity right after reset");

endmodule

bind register_hazard_detector rhd_checker u_rhd_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_valid  (result_valid),
  .earlier_index (earlier_index),
  .later_index   (later_index),
  .last_of_item  (last_of_item)
);
`default_nettype wire
